FILE: rtl/sva_pkg.sv
// package for the small vector alu: operation and status codes, item word,
// saturation and magnitude helpers
// no dependencies
`default_nettype none

package sva_pkg;

    localparam int VEC_N     = 4;
    localparam int LANES_DEF = 4;
    localparam int FRAC_DEF  = 16;
    localparam int LEN_W     = 33;
    localparam int SQ_STEPS  = 32;
    localparam int SQ_LAT    = SQ_STEPS + 1;
    localparam int SUM_W     = 72;

    localparam logic signed [SUM_W-1:0] Q_MAX_X = 72'sd2147483647;
    localparam logic signed [SUM_W-1:0] Q_MIN_X = -72'sd2147483648;

    typedef enum logic [3:0] {
        OP_ADD, OP_ADD_S, OP_SUB, OP_SUB_S, OP_MUL, OP_MUL_S,
        OP_DIV, OP_DIV_S, OP_LEN, OP_NORM, OP_DOT, OP_CROSS
    } t_op;

    typedef enum logic [1:0] {ST_OK, ST_DZ, ST_SAT, ST_BAD} t_status;

    typedef struct packed {
        logic [3:0]              op;
        logic                    bad;
        logic [VEC_N-1:0]        on;
        logic [VEC_N-1:0][31:0]  a;
        logic [VEC_N-1:0][31:0]  ymag;
        logic [VEC_N-1:0]        qneg;
        logic [VEC_N-1:0][31:0]  res;
        logic [31:0]             sc;
        logic                    ovf;
    } t_item;

    function automatic logic [32:0] f_sat(input logic signed [SUM_W-1:0] v);
        if (v > Q_MAX_X) begin
            return {1'b1, 32'h7fff_ffff};
        end else if (v < Q_MIN_X) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [31:0] f_mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic f_uses_scalar(input logic [3:0] op);
        return (op == OP_ADD_S) || (op == OP_SUB_S) || (op == OP_MUL_S) || (op == OP_DIV_S);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sva_lane.sv
// one lane of the vector alu: operand select, multiply pair and add/sub
// depends on sva_pkg
`default_nettype none

module sva_lane (
    input  wire logic               i_clk,
    input  wire logic [3:0]         i_op,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    input  wire logic signed [31:0] i_s,
    input  wire logic signed [31:0] i_cx,
    input  wire logic signed [31:0] i_cy,
    input  wire logic signed [31:0] i_cz,
    input  wire logic signed [31:0] i_cw,
    input  wire logic               i_cross_en,
    output logic signed [65:0]      o_p0,
    output logic signed [65:0]      o_p1,
    output logic signed [32:0]      o_as
);
    import sva_pkg::*;

    logic signed [31:0] y;
    logic signed [32:0] n_x0, n_y0, n_x1, n_y1, n_u, n_v;
    logic               n_sub;
    logic signed [32:0] r_x0, r_y0, r_x1, r_y1, r_u, r_v;
    logic               r_sub;

    assign y = f_uses_scalar(i_op) ? i_s : i_b;

    always_comb begin
        n_x0  = '0;
        n_y0  = '0;
        n_x1  = '0;
        n_y1  = '0;
        n_u   = 33'(i_a);
        n_v   = 33'(y);
        n_sub = 1'b0;
        case (i_op)
            OP_ADD, OP_ADD_S: begin
                n_sub = 1'b0;
            end
            OP_SUB, OP_SUB_S: begin
                n_sub = 1'b1;
            end
            OP_MUL, OP_MUL_S: begin
                n_x0 = 33'(i_a);
                n_y0 = 33'(y);
            end
            OP_LEN, OP_NORM: begin
                n_x0 = 33'(i_a);
                n_y0 = 33'(i_a);
            end
            OP_DOT: begin
                n_x0 = 33'(i_a);
                n_y0 = 33'(i_b);
            end
            OP_CROSS: begin
                if (i_cross_en) begin
                    n_x0 = 33'(i_cx);
                    n_y0 = 33'(i_cy);
                    n_x1 = 33'(i_cz);
                    n_y1 = -33'(i_cw);
                end
            end
            default: begin
                n_sub = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x0  <= n_x0;
        r_y0  <= n_y0;
        r_x1  <= n_x1;
        r_y1  <= n_y1;
        r_u   <= n_u;
        r_v   <= n_v;
        r_sub <= n_sub;
        o_p0  <= 66'(r_x0) * 66'(r_y0);
        o_p1  <= 66'(r_x1) * 66'(r_y1);
        o_as  <= r_sub ? (r_u - r_v) : (r_u + r_v);
    end

endmodule

`default_nettype wire

FILE: rtl/sva_sqrt.sv
// pipelined rounded square root of a 64-bit sum, one root bit per stage
// depends on sva_pkg
`default_nettype none

module sva_sqrt (
    input  wire logic                   i_clk,
    input  wire logic [63:0]            i_sum,
    input  wire logic                   i_carry,
    output logic [sva_pkg::LEN_W-1:0]   o_len
);
    import sva_pkg::*;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] src;
        logic        cy;
    } t_sq;

    t_sq r_st [SQ_STEPS];
    t_sq n_st [SQ_STEPS];
    t_sq s_in;

    function automatic t_sq f_step(input t_sq s);
        t_sq         o;
        logic [35:0] rs;
        logic [35:0] tr;
        rs     = {s.rem, s.src[63:62]};
        tr     = {2'b00, s.root, 2'b01};
        o.src  = {s.src[61:0], 2'b00};
        o.cy   = s.cy;
        if (rs >= tr) begin
            o.rem  = 34'(rs - tr);
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = rs[33:0];
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    assign s_in = '{rem: '0, root: '0, src: i_sum, cy: i_carry};

    always_comb begin
        n_st[0] = f_step(s_in);
        for (int k = 1; k < SQ_STEPS; k++) begin
            n_st[k] = f_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
        if (r_st[SQ_STEPS-1].cy) begin
            o_len <= {1'b1, 32'h0000_0000};
        end else if (r_st[SQ_STEPS-1].rem > {2'b00, r_st[SQ_STEPS-1].root}) begin
            o_len <= {1'b0, r_st[SQ_STEPS-1].root} + 33'd1;
        end else begin
            o_len <= {1'b0, r_st[SQ_STEPS-1].root};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sva_div.sv
// pipelined restoring divider for one lane, one quotient bit per stage
// depends on sva_pkg
`default_nettype none

module sva_div #(
    parameter int NUM_W = 48
) (
    input  wire logic                       i_clk,
    input  wire logic [NUM_W-1:0]           i_num,
    input  wire logic [sva_pkg::LEN_W-1:0]  i_den,
    output logic [NUM_W-1:0]                o_quo
);
    import sva_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;
        logic [LEN_W-1:0] den;
    } t_dv;

    t_dv r_st [NUM_W];
    t_dv n_st [NUM_W];
    t_dv s_in;

    function automatic t_dv f_step(input t_dv s);
        t_dv          o;
        logic [LEN_W:0] rs;
        rs    = {s.rem, s.nq[NUM_W-1]};
        o.den = s.den;
        if (rs >= {1'b0, s.den}) begin
            o.rem = LEN_W'(rs - {1'b0, s.den});
            o.nq  = {s.nq[NUM_W-2:0], 1'b1};
        end else begin
            o.rem = rs[LEN_W-1:0];
            o.nq  = {s.nq[NUM_W-2:0], 1'b0};
        end
        return o;
    endfunction

    assign s_in = '{rem: '0, nq: i_num, den: i_den};

    always_comb begin
        n_st[0] = f_step(s_in);
        for (int k = 1; k < NUM_W; k++) begin
            n_st[k] = f_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
    end

    assign o_quo = r_st[NUM_W-1].nq;

endmodule

`default_nettype wire

FILE: rtl/small_vector_alu_core.sv
// top level of the small vector alu: lanes, merge, square root and dividers
// depends on sva_pkg, sva_lane, sva_sqrt, sva_div
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   command  | start, busy         | i_operation, i_dimension, i_a_*, i_b_*,
//            |                     | i_scalar_in
//   result   | o_done (one cycle)  | o_r_x, o_r_y, o_r_z, o_r_w, o_scalar_out,
//            |                     | o_status
//
// one word accepted every cycle; busy stays low
// the pipeline has three front stages, 33 square root stages,
// 32 + FRAC_BITS divider stages and the output register
// every word runs the full pipeline, so results leave in accept order
// synchronous reset clears the valid chain only; words in flight are dropped
`default_nettype none

module small_vector_alu_core #(
    parameter int LANES     = sva_pkg::LANES_DEF,
    parameter int FRAC_BITS = sva_pkg::FRAC_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_operation,
    input  wire logic [2:0]  i_dimension,
    input  wire logic signed [31:0] i_a_x,
    input  wire logic signed [31:0] i_a_y,
    input  wire logic signed [31:0] i_a_z,
    input  wire logic signed [31:0] i_a_w,
    input  wire logic signed [31:0] i_b_x,
    input  wire logic signed [31:0] i_b_y,
    input  wire logic signed [31:0] i_b_z,
    input  wire logic signed [31:0] i_b_w,
    input  wire logic signed [31:0] i_scalar_in,
    output logic             o_done,
    output logic signed [31:0] o_r_x,
    output logic signed [31:0] o_r_y,
    output logic signed [31:0] o_r_z,
    output logic signed [31:0] o_r_w,
    output logic signed [31:0] o_scalar_out,
    output logic [1:0]       o_status
);
    import sva_pkg::*;

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int LAT   = 4 + SQ_LAT + NUM_W;
    localparam logic signed [SUM_W-1:0] HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic [2:0]                dim_c;
    logic [VEC_N-1:0][31:0]    a_in, b_in, am, bm;
    logic [31:0]               y;
    t_item                     n_item1, r_item1, r_item2, n_item3, r_item3;
    logic signed [65:0]        p0 [VEC_N];
    logic signed [65:0]        p1 [VEC_N];
    logic signed [32:0]        as_v [VEC_N];
    logic signed [SUM_W-1:0]   dsum, rsum;
    logic [32:0]               sv;
    logic [63:0]               r_sq;
    logic                      r_cy;
    logic [LEN_W-1:0]          len;
    t_item                     r_dq [SQ_LAT];
    t_item                     r_dd [NUM_W];
    logic [LEN_W-1:0]          r_ld [NUM_W];
    t_item                     it4, it5;
    logic [LEN_W-1:0]          len5;
    logic [NUM_W-1:0]          num [VEC_N];
    logic [LEN_W-1:0]          den [VEC_N];
    logic [NUM_W-1:0]          quo [VEC_N];
    logic [LAT-2:0]            r_vld;
    logic signed [SUM_W-1:0]   qv;
    logic [32:0]               ov;
    logic [VEC_N-1:0][31:0]    n_res;
    logic [31:0]               n_sc;
    logic                      n_ovf, n_dz;
    logic [1:0]                n_st;
    logic [VEC_N-1:0][31:0]    r_res;
    logic [31:0]               r_sc;
    logic [1:0]                r_st;
    logic                      r_done;

    assign busy = 1'b0;
    assign a_in = {i_a_w, i_a_z, i_a_y, i_a_x};
    assign b_in = {i_b_w, i_b_z, i_b_y, i_b_x};

    always_comb begin
        if (i_dimension < 3'd2) begin
            dim_c = 3'd2;
        end else if (i_dimension > 3'(LANES)) begin
            dim_c = 3'(LANES);
        end else begin
            dim_c = i_dimension;
        end
    end

    // front: mask lanes and collect per-lane divide operands
    always_comb begin
        n_item1     = '0;
        n_item1.op  = i_operation;
        n_item1.bad = (i_operation > OP_CROSS) || ((i_operation == OP_CROSS) && (dim_c != 3'd3));
        y           = '0;
        for (int i = 0; i < VEC_N; i++) begin
            n_item1.on[i] = (3'(i) < dim_c);
            am[i]         = n_item1.on[i] ? a_in[i] : 32'd0;
            bm[i]         = n_item1.on[i] ? b_in[i] : 32'd0;
            y             = f_uses_scalar(i_operation) ? i_scalar_in : bm[i];
            n_item1.a[i]    = am[i];
            n_item1.ymag[i] = f_mag(y);
            n_item1.qneg[i] = (i_operation == OP_NORM) ? am[i][31] : (am[i][31] ^ y[31]);
        end
    end

    for (genvar i = 0; i < VEC_N; i++) begin : g_lane
        if (i < LANES) begin : g_on
            sva_lane u_lane (
                .i_clk      (i_clk),
                .i_op       (i_operation),
                .i_a        (am[i]),
                .i_b        (bm[i]),
                .i_s        (i_scalar_in),
                .i_cx       (am[(i+1)%3]),
                .i_cy       (bm[(i+2)%3]),
                .i_cz       (am[(i+2)%3]),
                .i_cw       (bm[(i+1)%3]),
                .i_cross_en ((i < 3) ? 1'b1 : 1'b0),
                .o_p0       (p0[i]),
                .o_p1       (p1[i]),
                .o_as       (as_v[i])
            );
            sva_div #(.NUM_W(NUM_W)) u_div (
                .i_clk (i_clk),
                .i_num (num[i]),
                .i_den (den[i]),
                .o_quo (quo[i])
            );
        end else begin : g_off
            assign p0[i]   = '0;
            assign p1[i]   = '0;
            assign as_v[i] = '0;
            assign quo[i]  = '0;
        end
    end

    // merge: element results, dot product and sum of squares
    always_comb begin
        n_item3 = r_item2;
        dsum    = '0;
        rsum    = '0;
        sv      = '0;
        for (int i = 0; i < VEC_N; i++) begin
            dsum = dsum + SUM_W'(p0[i]);
            if (r_item2.on[i]) begin
                case (r_item2.op)
                    OP_ADD, OP_ADD_S, OP_SUB, OP_SUB_S: begin
                        sv = f_sat(SUM_W'(as_v[i]));
                        n_item3.res[i] = sv[31:0];
                        n_item3.ovf    = n_item3.ovf | sv[32];
                    end
                    OP_MUL, OP_MUL_S, OP_CROSS: begin
                        rsum = (SUM_W'(p0[i]) + SUM_W'(p1[i]) + HALF) >>> FRAC_BITS;
                        sv   = f_sat(rsum);
                        n_item3.res[i] = sv[31:0];
                        n_item3.ovf    = n_item3.ovf | sv[32];
                    end
                    default: begin
                        n_item3.res[i] = '0;
                    end
                endcase
            end
        end
        if (r_item2.op == OP_DOT) begin
            sv          = f_sat((dsum + HALF) >>> FRAC_BITS);
            n_item3.sc  = sv[31:0];
            n_item3.ovf = sv[32];
        end
    end

    sva_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_sum   (r_sq),
        .i_carry (r_cy),
        .o_len   (len)
    );

    assign it4 = r_dq[SQ_LAT-1];

    always_comb begin
        for (int i = 0; i < VEC_N; i++) begin
            num[i] = {f_mag(it4.a[i]), {FRAC_BITS{1'b0}}};
            den[i] = (it4.op == OP_NORM) ? len : {1'b0, it4.ymag[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_item1 <= n_item1;
        r_item2 <= r_item1;
        r_item3 <= n_item3;
        r_sq    <= dsum[63:0];
        r_cy    <= dsum[64];
        r_dq[0] <= r_item3;
        for (int k = 1; k < SQ_LAT; k++) begin
            r_dq[k] <= r_dq[k-1];
        end
        r_dd[0] <= it4;
        r_ld[0] <= len;
        for (int k = 1; k < NUM_W; k++) begin
            r_dd[k] <= r_dd[k-1];
            r_ld[k] <= r_ld[k-1];
        end
    end

    assign it5  = r_dd[NUM_W-1];
    assign len5 = r_ld[NUM_W-1];

    // output: quotients, saturation, length and status
    always_comb begin
        n_res = it5.res;
        n_sc  = it5.sc;
        n_ovf = it5.ovf;
        n_dz  = 1'b0;
        qv    = '0;
        ov    = '0;
        for (int i = 0; i < VEC_N; i++) begin
            qv = {{(SUM_W-NUM_W){1'b0}}, quo[i]};
            qv = it5.qneg[i] ? -qv : qv;
            ov = f_sat(qv);
            if (it5.on[i]) begin
                if ((it5.op == OP_DIV) || (it5.op == OP_DIV_S)) begin
                    if (it5.ymag[i] == 32'd0) begin
                        n_res[i] = it5.a[i][31] ? 32'h8000_0000 : 32'h7fff_ffff;
                        n_dz     = 1'b1;
                    end else begin
                        n_res[i] = ov[31:0];
                        n_ovf    = n_ovf | ov[32];
                    end
                end else if (it5.op == OP_NORM) begin
                    if (len5 == '0) begin
                        n_res[i] = it5.a[i];
                    end else begin
                        n_res[i] = ov[31:0];
                        n_ovf    = n_ovf | ov[32];
                    end
                end
            end
        end
        if (it5.op == OP_LEN) begin
            ov    = f_sat({{(SUM_W-LEN_W){1'b0}}, len5});
            n_sc  = ov[31:0];
            n_ovf = ov[32];
        end
        if (it5.bad) begin
            n_res = '0;
            n_sc  = '0;
            n_st  = ST_BAD;
        end else if (n_dz) begin
            n_st  = ST_DZ;
        end else if (n_ovf) begin
            n_st  = ST_SAT;
        end else begin
            n_st  = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_sc  <= n_sc;
        r_st  <= n_st;
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[LAT-3:0], start & ~busy};
            r_done <= r_vld[LAT-2];
        end
    end

    assign o_done       = r_done;
    assign o_r_x        = r_res[0];
    assign o_r_y        = r_res[1];
    assign o_r_z        = r_res[2];
    assign o_r_w        = r_res[3];
    assign o_scalar_out = r_sc;
    assign o_status     = r_st;

endmodule

`default_nettype wire

FILE: rtl/sva_chk.sv
// port-level checker for the small vector alu and its bind to the top level
// depends on sva_pkg and small_vector_alu_core
`default_nettype none

module sva_chk #(
    parameter int FRAC_BITS = sva_pkg::FRAC_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [3:0]  i_operation,
    input wire logic        o_done,
    input wire logic [31:0] o_r_x,
    input wire logic [31:0] o_r_y,
    input wire logic [31:0] o_r_z,
    input wire logic [31:0] o_r_w,
    input wire logic [31:0] o_scalar_out,
    input wire logic [1:0]  o_status
);
    import sva_pkg::*;

    localparam int LAT = 4 + SQ_LAT + 32 + FRAC_BITS;

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result word without a command");

    a_dz_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_DZ)) |->
        (($past(i_operation, LAT) == OP_DIV) || ($past(i_operation, LAT) == OP_DIV_S)))
        else $error("divide by zero status on a non-divide word");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_BAD)) |->
        ((o_r_x == 32'd0) && (o_r_y == 32'd0) && (o_r_z == 32'd0) &&
         (o_r_w == 32'd0) && (o_scalar_out == 32'd0)))
        else $error("bad operation word with nonzero payload");

endmodule

bind small_vector_alu_core sva_chk #(.FRAC_BITS(FRAC_BITS)) u_sva_chk (.*);

`default_nettype wire
